// ===== design/bmpdec_pkg.sv =====
// ---------------------------------------------------------------------------
// bmpdec_pkg
// Result codes and header layout constants for the 24-bit bitmap stream
// decoder.
// ---------------------------------------------------------------------------
package bmpdec_pkg;

	typedef enum logic [2:0] {
		KIND_PIXEL     = 3'd0,
		KIND_HEADER_OK = 3'd1,
		KIND_BAD_SIG   = 3'd2,
		KIND_BAD_DEPTH = 3'd3,
		KIND_TOO_LARGE = 3'd4
	} kind_t;

	// signature bytes, file byte 0 then byte 1
	localparam logic [7:0]  SIG_BYTE0 = 8'h42;
	localparam logic [7:0]  SIG_BYTE1 = 8'h4D;
	localparam logic [15:0] BIT_DEPTH = 16'd24;

	// header byte positions at which a field is complete
	localparam logic [5:0] POS_SIG    = 6'd1;
	localparam logic [5:0] POS_WIDTH  = 6'd21;
	localparam logic [5:0] POS_HEIGHT = 6'd25;
	localparam logic [5:0] POS_DEPTH  = 6'd29;
	localparam logic [5:0] POS_LAST   = 6'd53;

	localparam int OUT_DIM_BITS = 16;

endpackage

// ===== design/bmp24_stream_decoder_core.sv =====
// ---------------------------------------------------------------------------
// bmp24_stream_decoder_core
// Parses a 24-bit bitmap file arriving one byte per transfer: checks the
// header, reports width and height, then turns BGR triples into RGB pixels,
// skipping row padding and flagging the final pixel.
// ---------------------------------------------------------------------------
//
//  channel  valid         ready         payload
//  input    data_valid    data_ready    data_byte, start_of_file
//  result   result_valid  result_ready  kind, red, green, blue,
//                                       image_width, image_height, pixel_last
//
// One byte per cycle sustained while the output register is not stalled. A byte
// is taken into the input register, where the parser state and the result are
// worked out together, and the result is then registered in the output register.
// The input register stalls only while a finished result waits in the
// output register and result_ready is low.
// Reset clears the parser to the start of a header.
// ---------------------------------------------------------------------------
module bmp24_stream_decoder_core #(
	parameter int DIM_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   data_valid,
	output logic                                   data_ready,
	input  logic [7:0]                             data_byte,
	input  logic                                   start_of_file,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic [2:0]                             kind,
	output logic [7:0]                             red,
	output logic [7:0]                             green,
	output logic [7:0]                             blue,
	output logic [bmpdec_pkg::OUT_DIM_BITS-1:0]    image_width,
	output logic [bmpdec_pkg::OUT_DIM_BITS-1:0]    image_height,
	output logic                                   pixel_last
);

	typedef enum logic [1:0] {
		MODE_HEADER,
		MODE_PIXEL,
		MODE_PAD,
		MODE_IDLE
	} mode_t;

	// bits of a 32-bit size field that fit in DIM_BITS; all others must be clear for the size to fit
	localparam logic [31:0] DimMask = (DIM_BITS >= 32) ? '1 :
		32'((64'(1) << DIM_BITS) - 64'(1));

	// input register
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                sof_s1;

	// parser state
	mode_t               mode_q,   mode_d;
	logic [5:0]          pos_q,    pos_d;
	logic [31:0]         shift_q,  shift_d;
	logic [DIM_BITS-1:0] width_q,  width_d;
	logic [DIM_BITS-1:0] height_q, height_d;
	logic                big_q,    big_d;
	logic [DIM_BITS-1:0] col_q,    col_d;
	logic [DIM_BITS-1:0] row_q,    row_d;
	logic [1:0]          phase_q,  phase_d;
	logic [7:0]          blue_q,   blue_d;
	logic [7:0]          green_q,  green_d;
	logic [1:0]          pad_q,    pad_d;

	// result register
	logic                         res_valid_q;
	bmpdec_pkg::kind_t            kind_q,   kind_d;
	logic [7:0]                   red_q,    red_d;
	logic [7:0]                   green_o_q, green_o_d;
	logic [7:0]                   blue_o_q, blue_o_d;
	logic [bmpdec_pkg::OUT_DIM_BITS-1:0] img_w_q, img_w_d;
	logic [bmpdec_pkg::OUT_DIM_BITS-1:0] img_h_q, img_h_d;
	logic                         last_q,   last_d;
	logic                         emit;

	logic                advance;
	logic                fire;
	mode_t               cur_mode;
	logic [5:0]          cur_pos;
	logic [31:0]         shift_nx;
	logic                shift_over;
	logic [DIM_BITS:0]   col_inc;
	logic [DIM_BITS:0]   row_inc;
	logic                is_last;
	logic [31:0]         width_ext;
	logic [31:0]         height_ext;

	assign advance    = !res_valid_q || result_ready;
	assign fire       = valid_s1 && advance;
	assign data_ready = !valid_s1 || advance;

	assign cur_mode   = sof_s1 ? MODE_HEADER : mode_q;
	assign cur_pos    = sof_s1 ? 6'd0 : pos_q;
	assign shift_nx   = {byte_s1, (sof_s1 ? 24'd0 : shift_q[31:8])};
	assign shift_over = |(shift_nx & ~DimMask);
	assign col_inc    = {1'b0, col_q} + {{DIM_BITS{1'b0}}, 1'b1};
	assign row_inc    = {1'b0, row_q} + {{DIM_BITS{1'b0}}, 1'b1};
	assign is_last    = (col_inc == {1'b0, width_q}) && (row_inc == {1'b0, height_q});
	assign width_ext  = 32'(width_q);
	assign height_ext = 32'(height_q);

	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		shift_d   = shift_q;
		width_d   = width_q;
		height_d  = height_q;
		big_d     = big_q;
		col_d     = col_q;
		row_d     = row_q;
		phase_d   = phase_q;
		blue_d    = blue_q;
		green_d   = green_q;
		pad_d     = pad_q;
		emit      = 1'b0;
		kind_d    = bmpdec_pkg::KIND_PIXEL;
		red_d     = '0;
		green_o_d = '0;
		blue_o_d  = '0;
		img_w_d   = '0;
		img_h_d   = '0;
		last_d    = 1'b0;

		if (fire) begin
			unique case (cur_mode)
				MODE_HEADER: begin
					mode_d  = MODE_HEADER;
					shift_d = shift_nx;
					pos_d   = cur_pos + 6'd1;
					if (cur_pos == bmpdec_pkg::POS_SIG) begin
						if (shift_nx[23:16] != bmpdec_pkg::SIG_BYTE0 ||
							shift_nx[31:24] != bmpdec_pkg::SIG_BYTE1) begin
							mode_d = MODE_IDLE;
							emit   = 1'b1;
							kind_d = bmpdec_pkg::KIND_BAD_SIG;
						end
					end else if (cur_pos == bmpdec_pkg::POS_WIDTH) begin
						width_d = shift_nx[DIM_BITS-1:0];
						big_d   = shift_over;
					end else if (cur_pos == bmpdec_pkg::POS_HEIGHT) begin
						height_d = shift_nx[DIM_BITS-1:0];
						big_d    = big_q || shift_over;
					end else if (cur_pos == bmpdec_pkg::POS_DEPTH) begin
						if (shift_nx[31:16] != bmpdec_pkg::BIT_DEPTH) begin
							mode_d = MODE_IDLE;
							emit   = 1'b1;
							kind_d = bmpdec_pkg::KIND_BAD_DEPTH;
						end else if (big_q) begin
							mode_d = MODE_IDLE;
							emit   = 1'b1;
							kind_d = bmpdec_pkg::KIND_TOO_LARGE;
						end
					end else if (cur_pos >= bmpdec_pkg::POS_LAST) begin
						pos_d   = cur_pos;
						col_d   = '0;
						row_d   = '0;
						phase_d = 2'd0;
						pad_d   = 2'd0;
						mode_d  = (width_q == '0 || height_q == '0) ? MODE_IDLE
							: MODE_PIXEL;
						emit    = 1'b1;
						kind_d  = bmpdec_pkg::KIND_HEADER_OK;
						img_w_d = width_ext[bmpdec_pkg::OUT_DIM_BITS-1:0];
						img_h_d = height_ext[bmpdec_pkg::OUT_DIM_BITS-1:0];
					end
				end
				MODE_PIXEL: begin
					unique case (phase_q)
						2'd0: begin
							blue_d  = byte_s1;
							phase_d = 2'd1;
						end
						2'd1: begin
							green_d = byte_s1;
							phase_d = 2'd2;
						end
						default: begin
							phase_d = 2'd0;
							col_d   = col_inc[DIM_BITS-1:0];
							if (col_inc >= {1'b0, width_q}) begin
								col_d = '0;
								row_d = row_inc[DIM_BITS-1:0];
								// row padding follows every row but the last
								if (!is_last && width_q[1:0] != 2'd0) begin
									pad_d  = width_q[1:0];
									mode_d = MODE_PAD;
								end
							end
							if (is_last) begin
								mode_d = MODE_IDLE;
							end
							emit      = 1'b1;
							kind_d    = bmpdec_pkg::KIND_PIXEL;
							red_d     = byte_s1;
							green_o_d = green_q;
							blue_o_d  = blue_q;
							last_d    = is_last;
						end
					endcase
				end
				MODE_PAD: begin
					pad_d = pad_q - 2'd1;
					if (pad_q == 2'd1) begin
						mode_d = MODE_PIXEL;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			byte_s1     <= '0;
			sof_s1      <= 1'b0;
			mode_q      <= MODE_HEADER;
			pos_q       <= '0;
			shift_q     <= '0;
			width_q     <= '0;
			height_q    <= '0;
			big_q       <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			phase_q     <= '0;
			blue_q      <= '0;
			green_q     <= '0;
			pad_q       <= '0;
			res_valid_q <= 1'b0;
			kind_q      <= bmpdec_pkg::KIND_PIXEL;
			red_q       <= '0;
			green_o_q   <= '0;
			blue_o_q    <= '0;
			img_w_q     <= '0;
			img_h_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (data_ready) begin
				valid_s1 <= data_valid;
				byte_s1  <= data_byte;
				sof_s1   <= start_of_file;
			end
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			shift_q  <= shift_d;
			width_q  <= width_d;
			height_q <= height_d;
			big_q    <= big_d;
			col_q    <= col_d;
			row_q    <= row_d;
			phase_q  <= phase_d;
			blue_q   <= blue_d;
			green_q  <= green_d;
			pad_q    <= pad_d;
			// result register loads only when empty or being drained
			if (emit) begin
				res_valid_q <= 1'b1;
				kind_q      <= kind_d;
				red_q       <= red_d;
				green_o_q   <= green_o_d;
				blue_o_q    <= blue_o_d;
				img_w_q     <= img_w_d;
				img_h_q     <= img_h_d;
				last_q      <= last_d;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign red          = red_q;
	assign green        = green_o_q;
	assign blue         = blue_o_q;
	assign image_width  = img_w_q;
	assign image_height = img_h_q;
	assign pixel_last   = last_q;

endmodule
